/* src/robot_safety_interlock_fsm_assert.svh */
// Assertion macros for the robot safety interlock.
// Used by the top level only; no other dependencies.
`ifndef ROBOT_SAFETY_INTERLOCK_FSM_ASSERT_SVH
`define ROBOT_SAFETY_INTERLOCK_FSM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rsi_pkg.sv */
// Shared types for the robot safety interlock: mode and cause codes,
// the sample and result layouts. No dependencies.
package rsi_pkg;

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_READY = 3'd1,
        MODE_RUN   = 3'd2,
        MODE_SLOW  = 3'd3,
        MODE_CSTOP = 3'd4,
        MODE_ESTOP = 3'd5,
        MODE_FAULT = 3'd6
    } t_mode;

    typedef enum logic [3:0] {
        CAUSE_INIT      = 4'd0,
        CAUSE_MOTOR     = 4'd1,
        CAUSE_SENSOR    = 4'd2,
        CAUSE_ESTOP     = 4'd3,
        CAUSE_CLIFF     = 4'd4,
        CAUSE_COMM      = 4'd5,
        CAUSE_RELEASED  = 4'd6,
        CAUSE_RESET_OK  = 4'd7,
        CAUSE_RESET_REQ = 4'd8,
        CAUSE_STOP      = 4'd9,
        CAUSE_READY     = 4'd10,
        CAUSE_SLOW      = 4'd11,
        CAUSE_RUN       = 4'd12
    } t_cause;

    // Declared from the top bit down, so estop lands in bit 0.
    typedef struct packed {
        logic       slow_req;
        logic       drive_req;
        logic       stop_request;
        logic       restart_req;
        logic       init_done;
        logic       grip_released;
        logic       low_battery;
        logic       sensor_fault;
        logic       motor_trip;
        logic       comm_timeout;
        logic [1:0] cliff;
        logic       estop;
    } t_sample;

    // Declared from the top bit down, so mode lands in bits 2:0.
    typedef struct packed {
        logic       drive_allowed;
        logic       restart_pending;
        logic [7:0] hazard_flags;
        t_cause     cause;
        t_mode      mode;
    } t_result;

    localparam int unsigned SampleBits = $bits(t_sample);
    localparam int unsigned ResultBits = $bits(t_result);
    localparam int unsigned InDataBits  = ((SampleBits + 7) / 8) * 8;
    localparam int unsigned OutDataBits = ((ResultBits + 7) / 8) * 8;

endpackage

/* src/robot_safety_interlock_fsm.sv */
// Top level of the robot safety interlock: input register, decision logic,
// result register and mode state. Uses rsi_pkg, rsi_core and the assert header.
//
//   channel   | dir | payload
//   ----------+-----+--------------------------------------------------
//   i_s_*     | in  | one safety sample per transfer (16-bit tdata)
//   o_m_*     | out | one result per sample (24-bit tdata)
//
// Each sample is registered in the input register and its result then in the
// result register, which drives the output; one sample is taken per cycle
// while the output is not stalled. The mode and latch registers feed rsi_core
// and are updated as each sample moves into the result register.
// Reset (synchronous, active low) empties both stages and sets mode init,
// latch clear. A stalled output holds its result while one more sample waits
// in the input register; the input then stalls.
`include "robot_safety_interlock_fsm_assert.svh"

module robot_safety_interlock_fsm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // bit 0 estop, 2:1 cliff, 3 comm_timeout, 4 motor_trip, 5 sensor_fault,
    // 6 low_battery, 7 grip_released, 8 init_done, 9 restart_req,
    // 10 stop_request, 11 drive_req, 12 slow_req, 15:13 zero
    input  logic [rsi_pkg::InDataBits-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // bits 2:0 mode, 6:3 cause, 14:7 hazard_flags, 15 restart_pending,
    // 16 drive_allowed, 23:17 zero
    output logic [rsi_pkg::OutDataBits-1:0]  o_m_tdata
);

    logic             r_in_valid;
    rsi_pkg::t_sample r_in_data;
    logic             r_out_valid;
    rsi_pkg::t_result r_out_data;
    rsi_pkg::t_mode   r_mode;
    logic             r_latch;

    rsi_pkg::t_mode   n_mode;
    logic             n_latch;
    rsi_pkg::t_result n_result;

    logic out_load;
    logic advance;

    logic stop_mode;
    logic drive_match;
    logic state_match;

    // Move a sample forward whenever the result register is free or drains
    assign out_load   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_load;
    assign o_s_tready = !r_in_valid || out_load;

    rsi_core u_core (
        .i_sample (r_in_data),
        .i_mode   (r_mode),
        .i_latch  (r_latch),
        .o_mode   (n_mode),
        .o_latch  (n_latch),
        .o_result (n_result)
    );

    // Advance valid bits and the mode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= rsi_pkg::MODE_INIT;
            r_latch     <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_mode  <= n_mode;
                r_latch <= n_latch;
            end
        end
    end

    // Capture payloads on transfer and on advance
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_data <= rsi_pkg::t_sample'(i_s_tdata[rsi_pkg::SampleBits-1:0]);
        end
        if (advance) begin
            r_out_data <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(rsi_pkg::OutDataBits - rsi_pkg::ResultBits){1'b0}}, r_out_data};

    // Conditions watched by the checks below
    assign stop_mode   = (r_mode == rsi_pkg::MODE_CSTOP) || (r_mode == rsi_pkg::MODE_ESTOP) ||
                         (r_mode == rsi_pkg::MODE_FAULT);
    assign drive_match = r_out_data.drive_allowed ==
                         ((r_out_data.mode == rsi_pkg::MODE_RUN) ||
                          (r_out_data.mode == rsi_pkg::MODE_SLOW));
    assign state_match = (r_mode == r_out_data.mode) &&
                         (r_latch == r_out_data.restart_pending);

    // A set latch only ever follows a trip into a stopping mode
    `RSI_ASSERT_NOW(a_latch_mode, i_clk, i_rst_n, r_latch, stop_mode, "latch outside stop mode")

    // Drive permission must agree with the reported mode
    `RSI_ASSERT_NOW(a_drive_mode, i_clk, i_rst_n, r_out_valid, drive_match, "drive_allowed off")

    // The state registers follow the result that was just loaded
    `RSI_ASSERT_NEXT(a_state_tracks, i_clk, i_rst_n, advance, state_match, "state diverged")

endmodule

/* src/rsi_core.sv */
// Decision logic of the safety interlock: one sample plus the current
// mode and restart latch give the next mode, latch and result. Uses rsi_pkg.
module rsi_core (
    input  rsi_pkg::t_sample i_sample,
    input  rsi_pkg::t_mode   i_mode,
    input  logic             i_latch,
    output rsi_pkg::t_mode   o_mode,
    output logic             o_latch,
    output rsi_pkg::t_result o_result
);

    rsi_pkg::t_mode  n_mode;
    rsi_pkg::t_cause n_cause;
    logic            n_latch;

    // Walk the priority chain: hazards first, then init, latch and requests
    always_comb begin
        n_mode  = i_mode;
        n_latch = i_latch;
        n_cause = rsi_pkg::CAUSE_INIT;
        if (i_sample.motor_trip) begin
            n_mode  = rsi_pkg::MODE_FAULT;
            n_cause = rsi_pkg::CAUSE_MOTOR;
            n_latch = 1'b1;
        end else if (i_sample.sensor_fault) begin
            n_mode  = rsi_pkg::MODE_FAULT;
            n_cause = rsi_pkg::CAUSE_SENSOR;
            n_latch = 1'b1;
        end else if (i_sample.estop) begin
            n_mode  = rsi_pkg::MODE_ESTOP;
            n_cause = rsi_pkg::CAUSE_ESTOP;
            n_latch = 1'b1;
        end else if (i_sample.cliff != 2'b00) begin
            n_mode  = rsi_pkg::MODE_ESTOP;
            n_cause = rsi_pkg::CAUSE_CLIFF;
            n_latch = 1'b1;
        end else if (i_sample.comm_timeout) begin
            n_mode  = rsi_pkg::MODE_ESTOP;
            n_cause = rsi_pkg::CAUSE_COMM;
            n_latch = 1'b1;
        end else if (i_sample.grip_released) begin
            n_mode  = rsi_pkg::MODE_ESTOP;
            n_cause = rsi_pkg::CAUSE_RELEASED;
            n_latch = 1'b1;
        end else if (!i_sample.init_done) begin
            n_mode  = rsi_pkg::MODE_INIT;
            n_cause = rsi_pkg::CAUSE_INIT;
            n_latch = 1'b0;
        end else if (i_latch) begin
            // Hold the mode until a restart is requested
            if (i_sample.restart_req) begin
                n_mode  = rsi_pkg::MODE_READY;
                n_cause = rsi_pkg::CAUSE_RESET_OK;
                n_latch = 1'b0;
            end else begin
                n_cause = rsi_pkg::CAUSE_RESET_REQ;
            end
        end else if (i_sample.stop_request) begin
            n_mode  = rsi_pkg::MODE_CSTOP;
            n_cause = rsi_pkg::CAUSE_STOP;
            n_latch = 1'b1;
        end else if (!i_sample.drive_req) begin
            n_mode  = rsi_pkg::MODE_READY;
            n_cause = rsi_pkg::CAUSE_READY;
        end else if (i_sample.slow_req || i_sample.low_battery) begin
            n_mode  = rsi_pkg::MODE_SLOW;
            n_cause = rsi_pkg::CAUSE_SLOW;
        end else begin
            n_mode  = rsi_pkg::MODE_RUN;
            n_cause = rsi_pkg::CAUSE_RUN;
        end
    end

    // Pack the hazard flags and build the result
    always_comb begin
        o_result.mode            = n_mode;
        o_result.cause           = n_cause;
        o_result.hazard_flags    = {i_sample.grip_released, i_sample.low_battery,
                                    i_sample.sensor_fault, i_sample.motor_trip,
                                    i_sample.comm_timeout, i_sample.cliff,
                                    i_sample.estop};
        o_result.restart_pending = n_latch;
        o_result.drive_allowed   = (n_mode == rsi_pkg::MODE_RUN) ||
                                   (n_mode == rsi_pkg::MODE_SLOW);
    end

    assign o_mode  = n_mode;
    assign o_latch = n_latch;

endmodule
